// ===== rtl/core/rcpwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpwm_pkg
// Shared types and constants of the receiver pulse-width reconstructor.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

   localparam int CHANNELS   = 6;
   localparam int CHAN_W     = 3;
   localparam int TICK_W     = 16;
   localparam int PULSE_W    = 16;
   localparam int SCALE_W    = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   // reset values of the register file
   localparam logic [SCALE_W-1:0]    SCALE_RESET     = 24'd65536;
   localparam logic [PULSE_W-1:0]    MAX_PULSE_RESET = 16'd2500;
   localparam logic [PULSE_W-1:0]    STEP_RESET      = 16'd50;
   localparam logic [PULSE_W-1:0]    DEAD_BAND_RESET = 16'd10;
   localparam logic [CSR_DATA_W-1:0] CENTERS_RESET   = 48'h05DC_05DC_05DC;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COUNT_SCALE  = 3'd0,
      CSR_MAX_PULSE    = 3'd1,
      CSR_STEP_THRESH  = 3'd2,
      CSR_DEAD_BAND    = 3'd3,
      CSR_CENTERS_LOW  = 3'd4,
      CSR_CENTERS_HIGH = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SCALE_W-1:0]    count_scale_q16;
      logic [PULSE_W-1:0]    max_pulse_width;
      logic [PULSE_W-1:0]    step_threshold;
      logic [PULSE_W-1:0]    dead_band;
      logic [CSR_DATA_W-1:0] centers_low;
      logic [CSR_DATA_W-1:0] centers_high;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] chan_index;
      logic [TICK_W-1:0] tick_count;
   } req_item_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  chan_echo;
      logic [PULSE_W-1:0] pulse_us;
      logic               link_up;
   } rsp_item_type;

   // reading after scaling to microseconds
   typedef struct packed {
      logic [CHAN_W-1:0]  chan;
      logic [PULSE_W-1:0] curr;
   } scaled_item_type;

   // pipeline load enables from the top-level flow control
   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_out;
   } pipe_ctl_type;

endpackage

// ===== rtl/core/rcpwm_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpwm_csr
// Configuration register file; always ready, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module rcpwm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rcpwm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcpwm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rcpwm_pkg::cfg_type               cfg
);
   import rcpwm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COUNT_SCALE:  cfg_in.count_scale_q16 = csr_wdata[SCALE_W-1:0];
            CSR_MAX_PULSE:    cfg_in.max_pulse_width = csr_wdata[PULSE_W-1:0];
            CSR_STEP_THRESH:  cfg_in.step_threshold  = csr_wdata[PULSE_W-1:0];
            CSR_DEAD_BAND:    cfg_in.dead_band       = csr_wdata[PULSE_W-1:0];
            CSR_CENTERS_LOW:  cfg_in.centers_low     = csr_wdata;
            CSR_CENTERS_HIGH: cfg_in.centers_high    = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_scale_q16 <= SCALE_RESET;
         cfg_ff.max_pulse_width <= MAX_PULSE_RESET;
         cfg_ff.step_threshold  <= STEP_RESET;
         cfg_ff.dead_band       <= DEAD_BAND_RESET;
         cfg_ff.centers_low     <= CENTERS_RESET;
         cfg_ff.centers_high    <= CENTERS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/rcpwm_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpwm_scale
// Input register and Q16 tick-to-microsecond multiply, registered.
// ----------------------------------------------------------------------------
module rcpwm_scale (
   input  logic                          clock,
   input  rcpwm_pkg::pipe_ctl_type       ctl,
   input  rcpwm_pkg::req_item_type       req_item,
   input  logic [rcpwm_pkg::SCALE_W-1:0] count_scale_q16,
   output rcpwm_pkg::scaled_item_type    scaled
);
   import rcpwm_pkg::*;

   req_item_type                  s1_item_ff;
   scaled_item_type               s2_item_ff;
   scaled_item_type               s2_item_in;
   logic [TICK_W+SCALE_W-1:0]     product;

   // 16 x 24 multiply; keep bits 31:16 (>> 16, truncated to 16 bits)
   assign product = TICK_W'(s1_item_ff.tick_count) * count_scale_q16;

   always_comb begin
      s2_item_in.chan = s1_item_ff.chan_index;
      s2_item_in.curr = product[PULSE_W+15:16];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         s1_item_ff <= req_item;
      end
      if (ctl.load_s2) begin
         s2_item_ff <= s2_item_in;
      end
   end

   assign scaled = s2_item_ff;

endmodule

// ===== rtl/core/rcpwm_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpwm_track
// Per-channel partial/accepted widths, merge and step filter, dead band,
// link flag, and the result register.
// ----------------------------------------------------------------------------
module rcpwm_track (
   input  logic                       clock,
   input  logic                       reset,
   input  rcpwm_pkg::pipe_ctl_type    ctl,
   input  rcpwm_pkg::scaled_item_type scaled,
   input  rcpwm_pkg::cfg_type         cfg,
   output rcpwm_pkg::rsp_item_type    rsp_item
);
   import rcpwm_pkg::*;

   logic [PULSE_W-1:0] partial_ff  [CHANNELS];
   logic [PULSE_W-1:0] accepted_ff [CHANNELS];
   logic [PULSE_W-1:0] accepted_nx [CHANNELS];
   rsp_item_type       rsp_item_ff;
   rsp_item_type       rsp_item_in;

   logic               chan_ok;
   logic [CHAN_W-1:0]  idx;
   logic [PULSE_W-1:0] p1;
   logic [PULSE_W-1:0] p2;
   logic [PULSE_W:0]   sum;
   logic [PULSE_W:0]   d1;
   logic [PULSE_W:0]   d2;
   logic               merge;
   logic [PULSE_W-1:0] p1_in;
   logic [PULSE_W-1:0] p2_in;
   logic [PULSE_W-1:0] center;
   logic               snap;
   logic               link;

   // magnitude of a 16-bit two's complement value; -32768 gives 32768
   function automatic logic [PULSE_W:0] mag16(input logic [PULSE_W-1:0] v);
      logic [PULSE_W:0] r;
      if (v[PULSE_W-1]) begin
         r = {1'b1, {PULSE_W{1'b0}}} - {1'b0, v};
      end else begin
         r = {1'b0, v};
      end
      return r;
   endfunction

   assign chan_ok = (scaled.chan < CHAN_W'(CHANNELS));
   assign idx     = chan_ok ? scaled.chan : '0;

   always_comb begin
      p1    = partial_ff[idx];
      p2    = accepted_ff[idx];
      sum   = {1'b0, scaled.curr} + {1'b0, p1};
      d1    = mag16(sum[PULSE_W-1:0] - p2);
      d2    = mag16(p1 - p2);
      merge = (d1 < d2) && (sum < {1'b0, cfg.max_pulse_width});
      if (merge) begin
         p1_in = sum[PULSE_W-1:0];
         p2_in = (d1 > {1'b0, cfg.step_threshold}) ? sum[PULSE_W-1:0] : p2;
      end else begin
         p1_in = scaled.curr;
         p2_in = (d2 > {1'b0, cfg.step_threshold}) ? p1 : p2;
      end
   end

   always_comb begin
      case (idx)
         3'd0:    center = cfg.centers_low[15:0];
         3'd1:    center = cfg.centers_low[31:16];
         3'd2:    center = cfg.centers_low[47:32];
         3'd3:    center = cfg.centers_high[15:0];
         3'd4:    center = cfg.centers_high[31:16];
         3'd5:    center = cfg.centers_high[47:32];
         default: center = '0;
      endcase
   end

   assign snap = mag16(p2_in - center) < {1'b0, cfg.dead_band};

   // link looks at the accepted widths as they stand after this update
   always_comb begin
      link = 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
         accepted_nx[i] = (chan_ok && idx == CHAN_W'(i)) ? p2_in : accepted_ff[i];
         if (i > 0 && accepted_nx[i] != '0) begin
            link = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_item_in.chan_echo = scaled.chan;
      rsp_item_in.pulse_us  = !chan_ok ? '0 : (snap ? center : p2_in);
      rsp_item_in.link_up   = link;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            partial_ff[i]  <= '0;
            accepted_ff[i] <= '0;
         end
      end else if (ctl.load_out && chan_ok) begin
         partial_ff[idx]  <= p1_in;
         accepted_ff[idx] <= p2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_item = rsp_item_ff;

endmodule

// ===== rtl/core/rc_pwm_pulse_reconstructor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pwm_pulse_reconstructor
// Rebuilds per-channel receiver pulse widths in microseconds from high-time
// counter readings, with split-reading merge, step filter, dead-band snap
// to each channel's center, and a link flag.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  req_*    | in        | req_valid/req_stall  | chan_index, tick_count
//  rsp_*    | out       | rsp_valid/rsp_stall  | chan_echo, pulse_us, link_up
//  csr_*    | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
//  Three-stage pipeline: input register, Q16 multiply register, then the
//  per-channel update which loads the result register. Throughput is one
//  item per cycle unless the output stalls; the state read-modify-write
//  sits in the last stage, so back-to-back items on the same channel need
//  no bypass. Reset clears channel state and loads register defaults; no
//  clearing pass. Stages collapse bubbles: input keeps being taken while a
//  result is stalled, until every stage holds an item.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_reconstructor (
   input  logic                             clock,
   input  logic                             reset,
   // input items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rcpwm_pkg::req_item_type          req_item,
   // result items
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rcpwm_pkg::rsp_item_type          rsp_item,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rcpwm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcpwm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rcpwm_pkg::*;

   cfg_type         cfg;
   scaled_item_type scaled;
   pipe_ctl_type    ctl;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, s2_free, s1_free;
   logic s1_move, s2_move, accept;

   // flow control: a stage moves when the one after it is empty or moving
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_move  = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_move  = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s2_free;

   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   always_comb begin
      ctl.load_s1  = accept;
      ctl.load_s2  = s1_move;
      ctl.load_out = s2_move;
   end

   always_comb begin
      s1_valid_in  = accept  ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   rcpwm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rcpwm_scale u_scale (
      .clock           (clock),
      .ctl             (ctl),
      .req_item        (req_item),
      .count_scale_q16 (cfg.count_scale_q16),
      .scaled          (scaled)
   );

   rcpwm_track u_track (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .scaled   (scaled),
      .cfg      (cfg),
      .rsp_item (rsp_item)
   );

   // an accepted item always lands in the first stage
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted item not held in input stage");

   // a new result only comes out of a full multiply stage
   a_rsp_from_s2: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("result appeared without a source item");

   // a stalled result keeps the item behind it in place
   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && rsp_valid_ff && rsp_stall) |=> s2_valid_ff)
      else $error("item dropped behind a stalled result");

   // a taken result with nothing behind it leaves the output empty
   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !s2_valid_ff) |=> !rsp_valid_ff)
      else $error("result repeated after being taken");

endmodule
